>>> src/bsnm_pkg.sv
// ----------------------------------------------------------------------------
// bsnm_pkg
// Shared types and constants of the box set nearest merge check block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsnm_pkg;

   // Request operation codes.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_LOAD_LOWER = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_UPPER = 2'd1;
   localparam logic [OP_W-1:0] OP_EVALUATE   = 2'd2;

   // Response status codes.
   localparam int STATUS_W = 2;
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_CHECKED  = 2'd0;
   localparam status_type STATUS_MISMATCH = 2'd1;
   localparam status_type STATUS_EMPTY    = 2'd2;
   localparam status_type STATUS_OVERFLOW = 2'd3;

   // Configuration register indexes and widths.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT       = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MILEAGE_INTERVAL   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_THRESHOLD = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_THRESHOLD     = 8'd3;

   localparam int HEIGHT_W   = 13;
   localparam int MILEAGE_W  = 32;
   localparam int DIST_THR_W = 14;
   localparam int EDGE_THR_W = 13;

   // Mileage tolerance of 0.01 expressed in thousandths.
   localparam logic [MILEAGE_W-1:0] MILEAGE_TOL = 32'd10;

   // Response field widths.
   localparam int INDEX_OUT_W = 6;
   localparam int DIST_OUT_W  = 29;

   // Depth of the pair pipeline, waited out in the drain state after the walk.
   localparam int PIPE_LAT = 3;
   localparam int DRAIN_W  = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_lower;
      logic load_upper;
      logic capture;
      logic check;
      logic walk_valid;
      logic walk_first;
      logic emit;
   } cmd_type;

endpackage

`default_nettype wire

>>> src/bsnm_ram.sv
// ----------------------------------------------------------------------------
// bsnm_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnm_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/bsnm_ctrl.sv
// ----------------------------------------------------------------------------
// bsnm_ctrl
// Sequencer: decodes requests, runs the status check, walks every
// lower/upper pair and issues the response.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnm_ctrl #(
   parameter int IDX_W = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [bsnm_pkg::OP_W-1:0]  op,
   input  wire bsnm_pkg::status_type       sts,
   input  wire logic [IDX_W-1:0]           lower_last,
   input  wire logic [IDX_W-1:0]           upper_last,
   output logic                            busy,
   output bsnm_pkg::cmd_type               cmd,
   output logic [IDX_W-1:0]                lower_addr,
   output logic [IDX_W-1:0]                upper_addr
);

   import bsnm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      drain_in = drain_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op)
                  OP_LOAD_LOWER: cmd.load_lower = 1'b1;
                  OP_LOAD_UPPER: cmd.load_upper = 1'b1;
                  OP_EVALUATE: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            i_in      = '0;
            j_in      = '0;
            if (sts == STATUS_CHECKED) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            cmd.walk_valid = 1'b1;
            cmd.walk_first = (i_ff == '0) && (j_ff == '0);
            if (j_ff == upper_last) begin
               j_in = '0;
               if (i_ff == lower_last) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == DRAIN_W'(PIPE_LAT - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         drain_ff <= drain_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign lower_addr = i_ff;
   assign upper_addr = j_ff;

endmodule

`default_nettype wire

>>> src/bsnm_datapath.sv
// ----------------------------------------------------------------------------
// bsnm_datapath
// Rectangle stores, mileage and status check, pipelined pair distance and
// nearest pair tracking, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnm_datapath #(
   parameter int MAX_BOXES  = 64,
   parameter int COORD_BITS = 13,
   parameter int IDX_W      = 6
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bsnm_pkg::cmd_type                     cmd,
   input  wire logic [IDX_W-1:0]                      lower_addr,
   input  wire logic [IDX_W-1:0]                      upper_addr,
   input  wire logic [COORD_BITS-1:0]                 corner_a_x,
   input  wire logic [COORD_BITS-1:0]                 corner_a_y,
   input  wire logic [COORD_BITS-1:0]                 corner_b_x,
   input  wire logic [COORD_BITS-1:0]                 corner_b_y,
   input  wire logic [bsnm_pkg::MILEAGE_W-1:0]        lower_mileage,
   input  wire logic [bsnm_pkg::MILEAGE_W-1:0]        upper_mileage,
   input  wire logic [bsnm_pkg::HEIGHT_W-1:0]         image_height,
   input  wire logic [bsnm_pkg::MILEAGE_W-1:0]        mileage_interval,
   input  wire logic [bsnm_pkg::DIST_THR_W-1:0]       distance_threshold,
   input  wire logic [bsnm_pkg::EDGE_THR_W-1:0]       edge_threshold,
   output bsnm_pkg::status_type                       sts,
   output logic [IDX_W-1:0]                           lower_last,
   output logic [IDX_W-1:0]                           upper_last,
   output logic                                       rsp_valid,
   output logic                                       rsp_mergeable,
   output logic [bsnm_pkg::STATUS_W-1:0]              rsp_status,
   output logic [bsnm_pkg::INDEX_OUT_W-1:0]           rsp_upper_index,
   output logic [bsnm_pkg::INDEX_OUT_W-1:0]           rsp_lower_index,
   output logic [bsnm_pkg::DIST_OUT_W-1:0]            rsp_distance_squared
);

   import bsnm_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int ENT_W = 3 * COORD_BITS;
   localparam int HW    = (COORD_BITS > HEIGHT_W) ? COORD_BITS : HEIGHT_W;
   localparam int SW    = HW + 1;
   localparam int D2W   = 2 * SW + 1;
   localparam int LW    = (COORD_BITS > EDGE_THR_W) ? COORD_BITS : EDGE_THR_W;
   localparam int T2W   = 2 * DIST_THR_W;

   // ---------------------------------------------------------------- stores
   logic [CNT_W-1:0] lower_count_ff, upper_count_ff;
   logic             overflow_ff;
   logic             lower_full, upper_full;
   logic             lower_we, upper_we;
   logic [C:0]       sum_x, sum_y;
   logic [ENT_W-1:0] entry_wr;
   logic [ENT_W-1:0] lower_rd, upper_rd;

   assign lower_full = (lower_count_ff == CNT_W'(MAX_BOXES));
   assign upper_full = (upper_count_ff == CNT_W'(MAX_BOXES));
   assign lower_we   = cmd.load_lower && !lower_full;
   assign upper_we   = cmd.load_upper && !upper_full;

   // Entry layout: center x, center y, left x.
   assign sum_x    = {1'b0, corner_a_x} + {1'b0, corner_b_x};
   assign sum_y    = {1'b0, corner_a_y} + {1'b0, corner_b_y};
   assign entry_wr = {sum_x[C:1], sum_y[C:1], corner_a_x};

   bsnm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BOXES)) u_lower_ram (
      .clock   (clock),
      .wr_en   (lower_we),
      .wr_addr (lower_count_ff[IDX_W-1:0]),
      .wr_data (entry_wr),
      .rd_addr (lower_addr),
      .rd_data (lower_rd)
   );

   bsnm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BOXES)) u_upper_ram (
      .clock   (clock),
      .wr_en   (upper_we),
      .wr_addr (upper_count_ff[IDX_W-1:0]),
      .wr_data (entry_wr),
      .rd_addr (upper_addr),
      .rd_data (upper_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_count_ff <= '0;
         upper_count_ff <= '0;
         overflow_ff    <= 1'b0;
      end else if (cmd.emit) begin
         lower_count_ff <= '0;
         upper_count_ff <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         if (lower_we) begin
            lower_count_ff <= lower_count_ff + 1'b1;
         end
         if (upper_we) begin
            upper_count_ff <= upper_count_ff + 1'b1;
         end
         if ((cmd.load_lower && lower_full) || (cmd.load_upper && upper_full)) begin
            overflow_ff <= 1'b1;
         end
      end
   end

   assign lower_last = IDX_W'(lower_count_ff - 1'b1);
   assign upper_last = IDX_W'(upper_count_ff - 1'b1);

   // ---------------------------------------------------------- status check
   logic [MILEAGE_W-1:0] gap_ff, gap_in;
   logic [MILEAGE_W-1:0] mile_diff;
   logic                 mile_ok;
   status_type           status_ff;
   logic [T2W-1:0]       thr2_ff;

   assign gap_in = (upper_mileage > lower_mileage) ? (upper_mileage - lower_mileage)
                                                   : (lower_mileage - upper_mileage);
   assign mile_diff = (gap_ff > mileage_interval) ? (gap_ff - mileage_interval)
                                                  : (mileage_interval - gap_ff);
   assign mile_ok = (mile_diff < MILEAGE_TOL);

   always_comb begin
      if (overflow_ff) begin
         sts = STATUS_OVERFLOW;
      end else if (!mile_ok) begin
         sts = STATUS_MISMATCH;
      end else if ((lower_count_ff == '0) || (upper_count_ff == '0)) begin
         sts = STATUS_EMPTY;
      end else begin
         sts = STATUS_CHECKED;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         gap_ff <= gap_in;
      end
      if (cmd.check) begin
         status_ff <= sts;
         thr2_ff   <= T2W'(distance_threshold) * T2W'(distance_threshold);
      end
   end

   // -------------------------------------------------------- pair pipeline
   logic             p1_valid_ff, p1_first_ff;
   logic [IDX_W-1:0] p1_i_ff, p1_j_ff;
   logic             p2_valid_ff, p2_first_ff;
   logic [IDX_W-1:0] p2_i_ff, p2_j_ff;
   logic [C-1:0]     p2_adx_ff;
   logic [SW-1:0]    p2_ady_ff;
   logic [C-1:0]     p2_left_l_ff, p2_left_u_ff;
   logic             p3_valid_ff, p3_first_ff;
   logic [IDX_W-1:0] p3_i_ff, p3_j_ff;
   logic [2*C-1:0]   p3_dx2_ff;
   logic [2*SW-1:0]  p3_dy2_ff;
   logic [C-1:0]     p3_left_l_ff, p3_left_u_ff;

   logic [C-1:0]     l_cx, l_cy, l_left, u_cx, u_cy, u_left;
   logic [SW-1:0]    l_cy_off, u_cy_ext;
   logic [C-1:0]     adx;
   logic [SW-1:0]    ady;
   logic [D2W-1:0]   pair_d2;

   assign {l_cx, l_cy, l_left} = lower_rd;
   assign {u_cx, u_cy, u_left} = upper_rd;
   assign l_cy_off = SW'(image_height) + SW'(l_cy);
   assign u_cy_ext = SW'(u_cy);
   assign adx = (l_cx > u_cx) ? (l_cx - u_cx) : (u_cx - l_cx);
   assign ady = (l_cy_off > u_cy_ext) ? (l_cy_off - u_cy_ext) : (u_cy_ext - l_cy_off);
   assign pair_d2 = D2W'(p3_dx2_ff) + D2W'(p3_dy2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.walk_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_first_ff  <= cmd.walk_first;
      p1_i_ff      <= lower_addr;
      p1_j_ff      <= upper_addr;
      p2_first_ff  <= p1_first_ff;
      p2_i_ff      <= p1_i_ff;
      p2_j_ff      <= p1_j_ff;
      p2_adx_ff    <= adx;
      p2_ady_ff    <= ady;
      p2_left_l_ff <= l_left;
      p2_left_u_ff <= u_left;
      p3_first_ff  <= p2_first_ff;
      p3_i_ff      <= p2_i_ff;
      p3_j_ff      <= p2_j_ff;
      p3_dx2_ff    <= (2*C)'(p2_adx_ff) * (2*C)'(p2_adx_ff);
      p3_dy2_ff    <= (2*SW)'(p2_ady_ff) * (2*SW)'(p2_ady_ff);
      p3_left_l_ff <= p2_left_l_ff;
      p3_left_u_ff <= p2_left_u_ff;
   end

   // Nearest pair: the first strict minimum in lower-major order is kept.
   logic [D2W-1:0]   best_d_ff;
   logic [IDX_W-1:0] best_i_ff, best_j_ff;
   logic [C-1:0]     best_left_l_ff, best_left_u_ff;

   always_ff @(posedge clock) begin
      if (p3_valid_ff && (p3_first_ff || (pair_d2 < best_d_ff))) begin
         best_d_ff      <= pair_d2;
         best_i_ff      <= p3_i_ff;
         best_j_ff      <= p3_j_ff;
         best_left_l_ff <= p3_left_l_ff;
         best_left_u_ff <= p3_left_u_ff;
      end
   end

   // ------------------------------------------------------------- response
   logic [C-1:0] edge_gap;
   logic         merge;
   logic         checked;

   assign edge_gap = (best_left_l_ff > best_left_u_ff) ? (best_left_l_ff - best_left_u_ff)
                                                       : (best_left_u_ff - best_left_l_ff);
   assign merge    = (best_d_ff < D2W'(thr2_ff)) && (LW'(edge_gap) < LW'(edge_threshold));
   assign checked  = (status_ff == STATUS_CHECKED);

   logic                   rsp_valid_ff;
   logic                   rsp_mergeable_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [INDEX_OUT_W-1:0] rsp_upper_index_ff, rsp_lower_index_ff;
   logic [DIST_OUT_W-1:0]  rsp_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         if (checked) begin
            rsp_mergeable_ff   <= merge;
            rsp_upper_index_ff <= INDEX_OUT_W'(best_j_ff);
            rsp_lower_index_ff <= INDEX_OUT_W'(best_i_ff);
            rsp_distance_ff    <= DIST_OUT_W'(best_d_ff);
         end else begin
            rsp_mergeable_ff   <= 1'b0;
            rsp_upper_index_ff <= '0;
            rsp_lower_index_ff <= '0;
            rsp_distance_ff    <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mergeable        = rsp_mergeable_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_upper_index      = rsp_upper_index_ff;
   assign rsp_lower_index      = rsp_lower_index_ff;
   assign rsp_distance_squared = rsp_distance_ff;

endmodule

`default_nettype wire

>>> src/box_set_nearest_merge_check.sv
// ----------------------------------------------------------------------------
// box_set_nearest_merge_check
// Collects lower and upper image rectangles and decides whether the two
// image sets may be merged by mileage, nearest center and left edge checks.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge where start is high and busy is
// low. Op 0 and op 1 load one rectangle into the lower or the upper store;
// busy stays low, so loads can follow one per cycle. A load into a full store
// is dropped and marks the set as overflowed. Op 3 is ignored.
// Op 2 evaluates the collected sets. The block raises busy and first checks
// overflow, the mileage gap and empty stores. If those pass, it walks every
// lower/upper pair, one pair per cycle, through a three-stage distance
// pipeline fed by the two store RAMs. The pair walk is what sets the
// evaluate time; busy ends sooner when no pair walk is needed. The response
// is shown on the rsp_ ports for exactly one cycle, marked by rsp_valid, in
// the cycle in which busy falls.
// The receiver cannot stall the response. Every evaluate empties both stores.
// Configuration registers are written through the csr_ channel, which is
// always ready; they must only be written while the block is idle.
// Reset empties both stores, clears the overflow mark and zeroes the
// configuration registers; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module box_set_nearest_merge_check #(
   parameter int MAX_BOXES  = 64,
   parameter int COORD_BITS = 13
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [bsnm_pkg::OP_W-1:0]          req_op,
   input  wire logic [COORD_BITS-1:0]              req_corner_a_x,
   input  wire logic [COORD_BITS-1:0]              req_corner_a_y,
   input  wire logic [COORD_BITS-1:0]              req_corner_b_x,
   input  wire logic [COORD_BITS-1:0]              req_corner_b_y,
   input  wire logic [bsnm_pkg::MILEAGE_W-1:0]     req_lower_mileage,
   input  wire logic [bsnm_pkg::MILEAGE_W-1:0]     req_upper_mileage,
   // Response channel.
   output logic                                    rsp_valid,
   output logic                                    rsp_mergeable,
   output logic [bsnm_pkg::STATUS_W-1:0]           rsp_status,
   output logic [bsnm_pkg::INDEX_OUT_W-1:0]        rsp_upper_index,
   output logic [bsnm_pkg::INDEX_OUT_W-1:0]        rsp_lower_index,
   output logic [bsnm_pkg::DIST_OUT_W-1:0]         rsp_distance_squared,
   // Configuration channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bsnm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bsnm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import bsnm_pkg::*;

   // Store index width; a store of one entry still uses a one-bit address.
   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   // Configuration registers. Each write keeps the low bits that the
   // register holds; writes to unknown indexes are dropped.
   logic [HEIGHT_W-1:0]   image_height_ff;
   logic [MILEAGE_W-1:0]  mileage_interval_ff;
   logic [DIST_THR_W-1:0] distance_threshold_ff;
   logic [EDGE_THR_W-1:0] edge_threshold_ff;
   logic                  csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff       <= '0;
         mileage_interval_ff   <= '0;
         distance_threshold_ff <= '0;
         edge_threshold_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_HEIGHT:       image_height_ff       <= csr_wdata[HEIGHT_W-1:0];
            CSR_MILEAGE_INTERVAL:   mileage_interval_ff   <= csr_wdata[MILEAGE_W-1:0];
            CSR_DISTANCE_THRESHOLD: distance_threshold_ff <= csr_wdata[DIST_THR_W-1:0];
            CSR_EDGE_THRESHOLD:     edge_threshold_ff     <= csr_wdata[EDGE_THR_W-1:0];
            default: ;
         endcase
      end
   end

   // The controller sequences each request; the datapath holds the stores,
   // the distance pipeline and the response register.
   cmd_type          cmd;
   status_type       sts;
   logic [IDX_W-1:0] lower_addr, upper_addr;
   logic [IDX_W-1:0] lower_last, upper_last;

   bsnm_ctrl #(.IDX_W(IDX_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_op),
      .sts        (sts),
      .lower_last (lower_last),
      .upper_last (upper_last),
      .busy       (busy),
      .cmd        (cmd),
      .lower_addr (lower_addr),
      .upper_addr (upper_addr)
   );

   bsnm_datapath #(
      .MAX_BOXES  (MAX_BOXES),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .lower_addr           (lower_addr),
      .upper_addr           (upper_addr),
      .corner_a_x           (req_corner_a_x),
      .corner_a_y           (req_corner_a_y),
      .corner_b_x           (req_corner_b_x),
      .corner_b_y           (req_corner_b_y),
      .lower_mileage        (req_lower_mileage),
      .upper_mileage        (req_upper_mileage),
      .image_height         (image_height_ff),
      .mileage_interval     (mileage_interval_ff),
      .distance_threshold   (distance_threshold_ff),
      .edge_threshold       (edge_threshold_ff),
      .sts                  (sts),
      .lower_last           (lower_last),
      .upper_last           (upper_last),
      .rsp_valid            (rsp_valid),
      .rsp_mergeable        (rsp_mergeable),
      .rsp_status           (rsp_status),
      .rsp_upper_index      (rsp_upper_index),
      .rsp_lower_index      (rsp_lower_index),
      .rsp_distance_squared (rsp_distance_squared)
   );

endmodule

`default_nettype wire

>>> src/bsnm_checker.sv
// ----------------------------------------------------------------------------
// bsnm_checker
// Port-level checks of the request and response timing of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module bsnm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic [bsnm_pkg::OP_W-1:0]           req_op,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_mergeable,
   input wire logic [bsnm_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic [bsnm_pkg::INDEX_OUT_W-1:0]    rsp_upper_index,
   input wire logic [bsnm_pkg::INDEX_OUT_W-1:0]    rsp_lower_index,
   input wire logic [bsnm_pkg::DIST_OUT_W-1:0]     rsp_distance_squared
);

   import bsnm_pkg::*;

   // An accepted evaluate request always occupies the block.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_EVALUATE)) |=> busy)
      else $error("evaluate request did not raise busy");

   // A response ends a busy period and the block is free while it is shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response not at the end of a busy period");

   // Responses never come in adjacent cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // A failed precheck reports nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_CHECKED)) |->
         (!rsp_mergeable && (rsp_upper_index == '0) && (rsp_lower_index == '0)
          && (rsp_distance_squared == '0)))
      else $error("failed precheck carries pair data");

endmodule

bind box_set_nearest_merge_check bsnm_checker u_bsnm_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_op               (req_op),
   .rsp_valid            (rsp_valid),
   .rsp_mergeable        (rsp_mergeable),
   .rsp_status           (rsp_status),
   .rsp_upper_index      (rsp_upper_index),
   .rsp_lower_index      (rsp_lower_index),
   .rsp_distance_squared (rsp_distance_squared)
);

`default_nettype wire
